>>> sv/hmip_pkg.sv
// Shared types, constants and helper functions for the hex memory-image parser.
package hmip_pkg;

    localparam int DATA_BITS = 32;
    localparam int ADDR_BITS = 16;
    localparam int CHAR_BITS = 8;

    localparam logic [CHAR_BITS-1:0] CHAR_AT         = 8'h40;
    localparam logic [CHAR_BITS-1:0] CHAR_UNDERSCORE = 8'h5f;
    localparam logic [CHAR_BITS-1:0] CHAR_SPACE      = 8'h20;
    localparam logic [CHAR_BITS-1:0] CHAR_TAB        = 8'h09;
    localparam logic [CHAR_BITS-1:0] CHAR_NEWLINE    = 8'h0a;
    localparam logic [CHAR_BITS-1:0] CHAR_SLASH      = 8'h2f;

    localparam int DIGIT_BITS = 4;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_DATA,
        MODE_ADDR,
        MODE_SLASH,
        MODE_COMMENT
    } scan_mode_t;

    typedef enum logic {
        KIND_DATUM,
        KIND_ERROR
    } result_kind_t;

    typedef struct packed {
        scan_mode_t           mode;
        logic [DATA_BITS-1:0] accumulator;
        logic                 digit_seen;
        logic [ADDR_BITS-1:0] current_address;
        logic                 error_latched;
    } scan_state_t;

    typedef struct packed {
        logic                 valid;
        result_kind_t         kind;
        logic [ADDR_BITS-1:0] address;
        logic [DATA_BITS-1:0] value;
    } scan_result_t;

    function automatic logic is_hex(input logic [CHAR_BITS-1:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [DIGIT_BITS-1:0] hex_digit(input logic [CHAR_BITS-1:0] c);
        logic [CHAR_BITS-1:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
        end
        return v[DIGIT_BITS-1:0];
    endfunction

endpackage

>>> sv/hmip_step.sv
// Next-state and result logic for one character of the memory-image text.
module hmip_step (
    input  hmip_pkg::scan_state_t               state,
    input  logic [hmip_pkg::CHAR_BITS-1:0]      char_in,
    input  logic                                end_of_text,
    output hmip_pkg::scan_state_t               state_next,
    output hmip_pkg::scan_result_t              result
);

    logic                              hex;
    logic [hmip_pkg::DIGIT_BITS-1:0]   digit;
    logic                              ws;
    logic                              close_req;
    logic                              raise_req;
    logic                              slash_after;

    assign hex   = hmip_pkg::is_hex(char_in);
    assign digit = hmip_pkg::hex_digit(char_in);
    assign ws    = (char_in == hmip_pkg::CHAR_SPACE) || (char_in == hmip_pkg::CHAR_TAB) ||
                   (char_in == hmip_pkg::CHAR_NEWLINE);

    always_comb
    begin
        state_next     = state;
        close_req      = 1'b0;
        raise_req      = 1'b0;
        slash_after    = 1'b0;
        result.valid   = 1'b0;
        result.kind    = hmip_pkg::KIND_DATUM;
        result.address = state.current_address;
        result.value   = '0;

        if (!state.error_latched) begin
            if (end_of_text) begin
                if (state.mode == hmip_pkg::MODE_DATA || state.mode == hmip_pkg::MODE_ADDR) begin
                    close_req = 1'b1;
                end
                else if (state.mode == hmip_pkg::MODE_SLASH) begin
                    raise_req = 1'b1;
                end
                else begin
                    state_next.mode = hmip_pkg::MODE_IDLE;
                end
            end
            else begin
                case (state.mode)
                    hmip_pkg::MODE_IDLE:
                    begin
                        if (ws) begin
                            state_next.mode = hmip_pkg::MODE_IDLE;
                        end
                        else if (char_in == hmip_pkg::CHAR_SLASH) begin
                            state_next.mode = hmip_pkg::MODE_SLASH;
                        end
                        else if (char_in == hmip_pkg::CHAR_AT ||
                                 char_in == hmip_pkg::CHAR_UNDERSCORE || hex) begin
                            state_next.mode = (char_in == hmip_pkg::CHAR_AT) ?
                                              hmip_pkg::MODE_ADDR : hmip_pkg::MODE_DATA;
                            state_next.accumulator = hex ?
                                {{(hmip_pkg::DATA_BITS-hmip_pkg::DIGIT_BITS){1'b0}}, digit} : '0;
                            state_next.digit_seen = hex;
                        end
                        else begin
                            raise_req = 1'b1;
                        end
                    end
                    hmip_pkg::MODE_DATA, hmip_pkg::MODE_ADDR:
                    begin
                        if (hex) begin
                            state_next.accumulator =
                                {state.accumulator[hmip_pkg::DATA_BITS-hmip_pkg::DIGIT_BITS-1:0],
                                 digit};
                            state_next.digit_seen = 1'b1;
                        end
                        else if (char_in == hmip_pkg::CHAR_UNDERSCORE) begin
                            state_next.digit_seen = state.digit_seen;
                        end
                        else if (ws) begin
                            close_req = 1'b1;
                        end
                        else if (char_in == hmip_pkg::CHAR_SLASH) begin
                            close_req   = 1'b1;
                            slash_after = 1'b1;
                        end
                        else begin
                            raise_req = 1'b1;
                        end
                    end
                    hmip_pkg::MODE_SLASH:
                    begin
                        if (char_in == hmip_pkg::CHAR_SLASH) begin
                            state_next.mode = hmip_pkg::MODE_COMMENT;
                        end
                        else begin
                            raise_req = 1'b1;
                        end
                    end
                    hmip_pkg::MODE_COMMENT:
                    begin
                        if (char_in == hmip_pkg::CHAR_NEWLINE) begin
                            state_next.mode = hmip_pkg::MODE_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next.mode = hmip_pkg::MODE_IDLE;
                    end
                endcase
            end

            // A token without any digit is malformed.
            if (close_req) begin
                state_next.mode = hmip_pkg::MODE_IDLE;
                if (!state.digit_seen) begin
                    raise_req = 1'b1;
                end
                else if (state.mode == hmip_pkg::MODE_ADDR) begin
                    state_next.current_address =
                        state.accumulator[hmip_pkg::ADDR_BITS-1:0];
                    if (slash_after) begin
                        state_next.mode = hmip_pkg::MODE_SLASH;
                    end
                end
                else begin
                    result.valid   = 1'b1;
                    result.kind    = hmip_pkg::KIND_DATUM;
                    result.value   = state.accumulator;
                    state_next.current_address = state.current_address + 1'b1;
                    if (slash_after) begin
                        state_next.mode = hmip_pkg::MODE_SLASH;
                    end
                end
            end

            if (raise_req) begin
                state_next.error_latched = 1'b1;
                state_next.mode          = hmip_pkg::MODE_IDLE;
                result.valid             = 1'b1;
                result.kind              = hmip_pkg::KIND_ERROR;
                result.value             = '0;
            end
        end
    end

endmodule

>>> sv/hmip_out_reg.sv
// Result register that holds an item while the receiver stalls.
module hmip_out_reg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  hmip_pkg::scan_result_t          result,
    input  logic                            out_stall,
    output logic                            free,
    output logic                            out_valid,
    output logic                            result_kind,
    output logic [hmip_pkg::ADDR_BITS-1:0]  word_address,
    output logic [hmip_pkg::DATA_BITS-1:0]  word_value
);

    logic                           valid_reg;
    logic                           valid_next;
    logic                           kind_reg;
    logic [hmip_pkg::ADDR_BITS-1:0] address_reg;
    logic [hmip_pkg::DATA_BITS-1:0] value_reg;

    assign free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (free) begin
            valid_next = load && result.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load && result.valid) begin
            kind_reg    <= result.kind;
            address_reg <= result.address;
            value_reg   <= result.value;
        end
    end

    assign out_valid    = valid_reg;
    assign result_kind  = kind_reg;
    assign word_address = address_reg;
    assign word_value   = value_reg;

endmodule

>>> sv/hex_memory_image_parser.sv
// Top level of the hex memory-image parser: input register, scan state and result register.
//
// Each input item carries one character of a hex memory-image text (char_in) or, with
// end_of_text high, the end marker that flushes a pending token. Items are taken on
// in_valid with in_stall low. Result items leave on out_valid with out_stall low: a datum
// (result_kind 0) with its word_address and word_value, or a single parse error
// (result_kind 1), after which all further items are taken and ignored until reset.
// The closing character passes the input register and the scan-state step into the result
// register, where out_valid rises. One item is accepted in every cycle while in_stall is
// low; the rate is set by the scan-state update between the input register and the result
// register. When the receiver stalls with a result held, the item in the input register
// waits and in_stall rises only while that register is full and cannot move on.
// The start address is written through cfg_valid/cfg_ready/cfg_data; the user must
// write it only while the block is idle, which the block itself does not enforce. A write
// loads the current address. cfg_ready is always high. Reset clears the scan state, sets
// the current address to zero, and empties both registers.
module hex_memory_image_parser (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [hmip_pkg::CHAR_BITS-1:0]  char_in,
    input  logic                            end_of_text,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            result_kind,
    output logic [hmip_pkg::ADDR_BITS-1:0]  word_address,
    output logic [hmip_pkg::DATA_BITS-1:0]  word_value,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hmip_pkg::ADDR_BITS-1:0]  cfg_data
);

    logic                           in_full_reg;
    logic                           in_full_next;
    logic [hmip_pkg::CHAR_BITS-1:0] char_reg;
    logic                           eot_reg;

    hmip_pkg::scan_state_t          state_reg;
    hmip_pkg::scan_state_t          state_next;
    hmip_pkg::scan_state_t          step_next;
    hmip_pkg::scan_result_t         step_result;

    logic                           out_free;
    logic                           fire;
    logic                           in_accept;

    assign cfg_ready = 1'b1;
    assign fire      = in_full_reg && out_free;
    assign in_stall  = in_full_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    hmip_step u_step (
        .state       (state_reg),
        .char_in     (char_reg),
        .end_of_text (eot_reg),
        .state_next  (step_next),
        .result      (step_result)
    );

    hmip_out_reg u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (fire),
        .result       (step_result),
        .out_stall    (out_stall),
        .free         (out_free),
        .out_valid    (out_valid),
        .result_kind  (result_kind),
        .word_address (word_address),
        .word_value   (word_value)
    );

    always_comb
    begin
        in_full_next = in_accept || (in_full_reg && !fire);
        state_next   = state_reg;
        if (fire) begin
            state_next = step_next;
        end
        if (cfg_valid && cfg_ready) begin
            state_next.current_address = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_full_reg                 <= 1'b0;
            state_reg.mode              <= hmip_pkg::MODE_IDLE;
            state_reg.accumulator       <= '0;
            state_reg.digit_seen        <= 1'b0;
            state_reg.current_address   <= '0;
            state_reg.error_latched     <= 1'b0;
        end
        else begin
            in_full_reg <= in_full_next;
            state_reg   <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept) begin
            char_reg <= char_in;
            eot_reg  <= end_of_text;
        end
    end

endmodule
